>>> src/dwmd_pkg.sv
// Shared constants and types for the distinct-window marker detector.
package dwmd_pkg;

    localparam int MAX_WINDOW_DEF = 16;   // default longest window
    localparam int ALPHABET_SIZE  = 26;   // letter codes 0..25
    localparam int LETTER_W       = 5;
    localparam int CFG_W          = 5;
    localparam int POS_W          = 16;
    localparam int LEN_MIN        = 2;
    localparam int LEN_RESET      = 4;

    // What one cell hands to the next one along the row
    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                valid;
        logic                dup;     // a newer equal letter sits nearer the head
    } cell_hand_t;

endpackage

>>> src/dwmd_cell.sv
// One cell of the letter row: holds a letter, its valid bit and a repeat flag.
module dwmd_cell
    import dwmd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                shift,
    input  logic [LETTER_W-1:0] probe,
    input  cell_hand_t          prev,
    output cell_hand_t          hand
);

    logic [LETTER_W-1:0] letter_reg;
    logic [LETTER_W-1:0] letter_next;
    logic                valid_reg;
    logic                valid_next;
    logic                dup_reg;
    logic                dup_next;
    logic                match;

    // incoming letter equals the one held here
    assign match = valid_reg & (letter_reg == probe);

    assign hand.letter = letter_reg;
    assign hand.valid  = valid_reg;
    assign hand.dup    = dup_reg | match;

    always_comb
    begin
        letter_next = letter_reg;
        valid_next  = valid_reg;
        dup_next    = dup_reg;
        if (clear)
        begin
            valid_next = 1'b0;
            dup_next   = 1'b0;
        end
        else if (shift)
        begin
            letter_next = prev.letter;
            valid_next  = prev.valid;
            dup_next    = prev.dup;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dup_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            dup_reg   <= dup_next;
        end
    end

    always_ff @(posedge clk)
    begin
        letter_reg <= letter_next;
    end

endmodule

>>> src/distinct_window_marker_detector_unit.sv
// Distinct-window marker detector: top level with the cell row and output register.
//
//  channel   | dir | carries                               | accepted when
//  ----------+-----+---------------------------------------+------------------------------
//  s_axis    | in  | tdata[4:0] letter, tlast end of line  | s_axis_tvalid & s_axis_tready
//  m_axis    | out | tdata[15:0] position, tuser found     | m_axis_tvalid & m_axis_tready
//  cfg       | in  | cfg_wr_data window length             | cfg_wr_en
//
// One word per cycle: a letter is compared against every held cell in the same
// cycle and the repeat flags of the window are OR-reduced, so the result of a
// word is decided in the cycle it is accepted and lands in the output register.
// m_axis_tvalid shows a word's result in the cycle after the word is accepted.
// The input stays ready while the output register is empty or being drained.
// rst_n clears the row, the counters and the output valid; window length
// returns to 4. A config write clears the line state as well.
module distinct_window_marker_detector_unit
    import dwmd_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [4:0] letter, [7:5] zero
    input  logic             s_axis_tlast,   // end_of_line
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [POS_W-1:0] m_axis_tdata,   // [15:0] position
    output logic             m_axis_tuser,   // [0] found
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data     // window_length
);

    localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W   = LEN_W + 1;
    localparam int NCELL   = MAX_WINDOW - 1;   // older letters that can share the window
    localparam int LEN_RST = (LEN_RESET > MAX_WINDOW) ? MAX_WINDOW : LEN_RESET;

    // window length in use, already clamped to 2..MAX_WINDOW
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] cfg_len;

    logic [POS_W-1:0] seen_reg;
    logic [POS_W-1:0] seen_next;
    logic [POS_W-1:0] seen_inc;
    logic             done_reg;
    logic             done_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_found_reg;
    logic             out_found_next;
    logic [POS_W-1:0] out_pos_reg;
    logic [POS_W-1:0] out_pos_next;

    logic [LETTER_W-1:0] letter;
    logic                eol;
    logic                s_fire;
    logic                m_fire;
    logic                letter_ok;
    logic                shift;
    logic                clear_line;
    logic                hit;
    logic                eol_result;
    logic                dup_any;
    logic                full;

    cell_hand_t          head;
    cell_hand_t          hand [NCELL];
    logic [NCELL-1:0]    dup_vec;
    logic [NCELL-1:0]    valid_vec;
    logic [NCELL-1:0]    in_win;

    assign letter = s_axis_tdata[LETTER_W-1:0];
    assign eol    = s_axis_tlast;

    // output register parts the two sides: take a word while the result drains
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid & s_axis_tready;
    assign m_fire        = out_valid_reg & m_axis_tready;

    // codes beyond the alphabet are dropped without touching state
    assign letter_ok  = letter < LETTER_W'(ALPHABET_SIZE);
    assign shift      = s_fire & !eol & !done_reg & letter_ok;
    assign clear_line = cfg_wr_en | (s_fire & eol);

    // new word enters the head of the row, never flagged itself
    assign head.letter = letter;
    assign head.valid  = 1'b1;
    assign head.dup    = 1'b0;

    // Cell k holds the letter from k+1 words back. Its hand is what it becomes
    // one place further down: the dup flag picks up a match with the new letter.
    genvar k;
    generate
        for (k = 0; k < NCELL; k++)
        begin : g_cell
            if (k == 0)
            begin : g_first
                dwmd_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .clear (clear_line),
                    .shift (shift),
                    .probe (letter),
                    .prev  (head),
                    .hand  (hand[k])
                );
            end
            else
            begin : g_rest
                dwmd_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .clear (clear_line),
                    .shift (shift),
                    .probe (letter),
                    .prev  (hand[k-1]),
                    .hand  (hand[k])
                );
            end
            assign dup_vec[k]   = hand[k].dup;
            assign valid_vec[k] = hand[k].valid;
            // after the shift this cell's hand lands at place k+1: inside the window
            // when k+1 < len
            assign in_win[k]    = CMP_W'(k + 2) <= {1'b0, len_reg};
        end
    endgenerate

    // A repeat inside the window always has its older copy flagged; copies
    // older than the window fall outside the mask. The row fills from the
    // head, so the window is full when every in-window hand is valid.
    assign dup_any = |(dup_vec & in_win);
    assign full    = &(valid_vec | ~in_win);

    assign hit        = shift & full & !dup_any;
    assign eol_result = s_fire & eol & !done_reg;

    // saturating letter count
    assign seen_inc = (seen_reg == {POS_W{1'b1}}) ? seen_reg : seen_reg + POS_W'(1);

    always_comb
    begin
        if (cfg_wr_data < CFG_W'(LEN_MIN))
            cfg_len = LEN_W'(LEN_MIN);
        else if (int'(cfg_wr_data) > MAX_WINDOW)
            cfg_len = LEN_W'(MAX_WINDOW);
        else
            cfg_len = LEN_W'(cfg_wr_data);
    end

    always_comb
    begin
        len_next  = cfg_wr_en ? cfg_len : len_reg;
        seen_next = seen_reg;
        done_next = done_reg;
        if (clear_line)
        begin
            seen_next = '0;
            done_next = 1'b0;
        end
        else if (shift)
        begin
            seen_next = seen_inc;
            done_next = hit;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_pos_next   = out_pos_reg;
        if (hit || eol_result)
        begin
            out_valid_next = 1'b1;
            out_found_next = hit;
            out_pos_next   = hit ? seen_inc : seen_reg;
        end
        else if (m_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= LEN_W'(LEN_RST);
            seen_reg      <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            seen_reg      <= seen_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pos_reg;
    assign m_axis_tuser  = out_found_reg;

endmodule

>>> src/dwmd_checker.sv
// Port-level checks for the distinct-window marker detector, bound to the top level.
module dwmd_checker
    import dwmd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [POS_W-1:0] m_axis_tdata,
    input logic             m_axis_tuser
);

    // a marker needs at least two letters
    a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata >= POS_W'(LEN_MIN))
        else $error("marker reported before two letters");

    // full output register that is not drained must block the input
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input ready while result stalled");

    // a new result only follows an accepted word
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result without accepted word");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind distinct_window_marker_detector_unit dwmd_checker u_dwmd_checker (.*);

>>> test/tb_distinct_window_marker_detector_unit.sv
// Self-checking testbench for the distinct-window marker detector, with its own line predictor.
module tb_distinct_window_marker_detector_unit;
    import dwmd_pkg::*;

    // Word idle for this many cycles in a row means the block has hung
    localparam int unsigned STALL_LIMIT = 4000;
    // Letter codes count from 'a'
    localparam byte         CHAR_A      = "a";

    // One word on the input stream, and one result on the output stream
    typedef struct {
        logic [LETTER_W-1:0] letter;
        logic                eol;
        bit                  drain_first;   // hold this word back until no result is owed
    } line_word_t;

    typedef struct {
        logic             found;
        logic [POS_W-1:0] position;
    } line_result_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata  = 8'h00;   // [4:0] letter, [7:5] zero
    logic             s_axis_tlast  = 1'b0;    // end_of_line
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [POS_W-1:0] m_axis_tdata;            // [15:0] position
    logic             m_axis_tuser;            // [0] found
    logic             cfg_wr_en     = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data   = '0;      // window_length

    distinct_window_marker_detector_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: a shadow of the line the block is working on
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]    win_cfg;
    logic [LETTER_W-1:0] window_letters [MAX_WINDOW_DEF];   // index 0 is newest
    int unsigned         letter_counts  [ALPHABET_SIZE];
    int unsigned         repeat_tally;
    logic [POS_W-1:0]    letters_seen;
    bit                  marker_done;

    line_word_t   pending_words [$];      // filled by the sequencer, drained by the driver
    line_result_t owed_results  [$];      // results the block still has to deliver

    int unsigned sender_idle_pct = 0;
    int unsigned sink_stall_pct  = 0;
    bit          word_taken      = 1'b0;  // set at the edge a word is accepted
    int unsigned queued_total    = 0;
    int unsigned accepted_total  = 0;
    int unsigned error_count     = 0;
    int unsigned idle_cycles     = 0;
    int unsigned lines_closed    = 0;
    int unsigned markers_checked = 0;
    int unsigned unmarked_checked = 0;
    int unsigned windows_written = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic void clear_line_state();
        for (int i = 0; i < MAX_WINDOW_DEF; i++)
            window_letters[i] = '0;
        for (int i = 0; i < ALPHABET_SIZE; i++)
            letter_counts[i] = 0;
        repeat_tally = 0;
        letters_seen = '0;
        marker_done  = 1'b0;
    endfunction

    // Lengths outside the legal span are clamped, not rejected
    function automatic int unsigned active_length();
        if (win_cfg < LEN_MIN)
            return LEN_MIN;
        if (win_cfg > MAX_WINDOW_DEF)
            return MAX_WINDOW_DEF;
        return 32'(win_cfg);
    endfunction

    // Advance the shadow line by one word; returns 1 when the word yields a result
    function automatic bit detect_step(input logic [LETTER_W-1:0] code, input logic eol,
                                       output line_result_t res);
        int unsigned len;
        int unsigned held;
        int unsigned old;
        int unsigned k;
        res.found    = 1'b0;
        res.position = '0;
        if (eol) begin
            // a line end reports the length only when no marker came first
            if (!marker_done) begin
                res.position = letters_seen;
                clear_line_state();
                return 1'b1;
            end
            clear_line_state();
            return 1'b0;
        end
        // out-of-range codes and letters after the marker leave no trace
        if (marker_done || code >= ALPHABET_SIZE)
            return 1'b0;
        len  = active_length();
        held = (32'(letters_seen) < len) ? 32'(letters_seen) : len;
        // the oldest letter drops out once the window is full
        if (held >= len) begin
            old = 32'(window_letters[len-1]);
            if (old < ALPHABET_SIZE && letter_counts[old] > 0) begin
                if (letter_counts[old] == 2 && repeat_tally > 0)
                    repeat_tally--;
                letter_counts[old]--;
            end
        end
        for (k = len - 1; k > 0; k--)
            window_letters[k] = window_letters[k-1];
        window_letters[0] = code;
        letter_counts[code]++;
        if (letter_counts[code] == 2)
            repeat_tally++;
        // position counter sticks at all ones
        if (letters_seen != '1)
            letters_seen++;
        if (held < len)
            held++;
        if (held >= len && repeat_tally == 0) begin
            marker_done  = 1'b1;
            res.found    = 1'b1;
            res.position = letters_seen;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: input stream and output ready change on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk) begin : drive_words
        line_word_t w;
        if (rst_n) begin
            if (!s_axis_tvalid || word_taken) begin
                if (pending_words.size() != 0
                        && !(pending_words[0].drain_first && owed_results.size() != 0)
                        && $urandom_range(99) >= sender_idle_pct) begin
                    w = pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {3'b000, w.letter};
                    s_axis_tlast  <= w.eol;
                end
                else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            word_taken = 1'b0;
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: both handshakes sampled on the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk) begin : watch_streams
        line_result_t got;
        line_result_t want;
        line_result_t res;
        bit           moved;
        if (rst_n) begin
            moved = 1'b0;
            // a result leaving now belongs to an older word, so check before predicting
            if (m_axis_tvalid && m_axis_tready) begin
                moved        = 1'b1;
                got.found    = m_axis_tuser;
                got.position = m_axis_tdata;
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result found=%0b position=%0d",
                                              got.found, got.position));
                end
                else begin
                    want = owed_results.pop_front();
                    if (got.found !== want.found)
                        report_mismatch($sformatf("found %0b, want %0b (position %0d)",
                                                  got.found, want.found, want.position));
                    if (got.position !== want.position)
                        report_mismatch($sformatf("position %0d, want %0d (found %0b)",
                                                  got.position, want.position, want.found));
                    if (want.found)
                        markers_checked++;
                    else
                        unmarked_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                moved      = 1'b1;
                word_taken = 1'b1;
                accepted_total++;
                if (s_axis_tlast)
                    lines_closed++;
                if (detect_step(s_axis_tdata[LETTER_W-1:0], s_axis_tlast, res))
                    owed_results.push_back(res);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles, %0d results owed",
                         idle_cycles, owed_results.size());
                $display("tb_distinct_window_marker_detector_unit: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_word(input logic [LETTER_W-1:0] code, input logic eol,
                              input bit drain);
        line_word_t w;
        w.letter      = code;
        w.eol         = eol;
        w.drain_first = drain;
        pending_words.push_back(w);
        queued_total++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_word(LETTER_W'(s[i] - CHAR_A), 1'b0, 1'b0);
    endtask

    // Letter with occasional junk code in front of it
    task automatic queue_letter(input logic [LETTER_W-1:0] code);
        if ($urandom_range(99) < 4)
            queue_word(LETTER_W'($urandom_range(ALPHABET_SIZE, 31)), 1'b0, 1'b0);
        queue_word(code, 1'b0, $urandom_range(99) == 0);
    endtask

    // Letter bits on a line end are don't-care, so randomise them
    task automatic queue_eol();
        queue_word(LETTER_W'($urandom_range(0, 31)), 1'b1, $urandom_range(99) == 0);
    endtask

    // One line; mostly a repeating lead-in followed by a planted distinct run
    task automatic queue_random_line(input int unsigned len);
        int unsigned         mode;
        int unsigned         n;
        int unsigned         k;
        int unsigned         base;
        int unsigned         run;
        int unsigned         i;
        int unsigned         j;
        logic [LETTER_W-1:0] perm [ALPHABET_SIZE];
        logic [LETTER_W-1:0] t;
        mode = $urandom_range(99);
        if (mode < 15) begin
            // free letters over the whole alphabet, empty lines included
            n = $urandom_range(0, 20);
            repeat (n) queue_letter(LETTER_W'($urandom_range(0, ALPHABET_SIZE - 1)));
        end
        else if (mode < 35) begin
            // narrow alphabet: usually ends without a marker
            k    = $urandom_range(1, len);
            base = $urandom_range(0, ALPHABET_SIZE - k);
            n    = $urandom_range(0, 3 * len);
            repeat (n) queue_letter(LETTER_W'(base + $urandom_range(0, k - 1)));
        end
        else begin
            k    = $urandom_range(1, 3);
            base = $urandom_range(0, ALPHABET_SIZE - k);
            n    = $urandom_range(0, 2 * len);
            repeat (n) queue_letter(LETTER_W'(base + $urandom_range(0, k - 1)));
            for (i = 0; i < ALPHABET_SIZE; i++)
                perm[i] = LETTER_W'(i);
            for (i = ALPHABET_SIZE - 1; i > 0; i--) begin
                j       = $urandom_range(0, i);
                t       = perm[i];
                perm[i] = perm[j];
                perm[j] = t;
            end
            // one short of the window now and then: a near miss
            run = ($urandom_range(99) < 20) ? len - 1 : len;
            for (i = 0; i < run; i++)
                queue_letter(perm[i]);
            n = $urandom_range(0, 3);
            repeat (n) queue_letter(LETTER_W'($urandom_range(0, ALPHABET_SIZE - 1)));
        end
        queue_eol();
    endtask

    // Idle means every word taken and every result delivered; the extra
    // cycles cover a last word that owes no result
    task automatic wait_for_drain();
        while (accepted_total != queued_total || owed_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        win_cfg = v;
        clear_line_state();
        windows_written++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] win, input int unsigned src_pct,
                             input int unsigned snk_pct, input int unsigned n_words);
        int unsigned start;
        wait_for_drain();
        write_window(win);
        sender_idle_pct = src_pct;
        sink_stall_pct  = snk_pct;
        start = queued_total;
        while (queued_total - start < n_words)
            queue_random_line(active_length());
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin : sequencer
        win_cfg = CFG_W'(LEN_RESET);
        clear_line_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed lines at the reset window of four, no idling
        queue_eol();                                 // empty line: length zero
        queue_text("xyza");                          // marker on the fourth letter
        queue_text("z");                             // ignored after the marker
        queue_eol();                                 // no result after a marker
        queue_word(LETTER_W'(31), 1'b0, 1'b0);       // junk codes are skipped
        queue_text("zz");
        queue_word(LETTER_W'(ALPHABET_SIZE), 1'b0, 1'b0);
        queue_eol();
        // sender waits here until the line-end result has gone out
        queue_word(LETTER_W'(0), 1'b0, 1'b1);
        queue_text("abcd");                          // marker once the repeat slides out
        queue_eol();
        queue_text("abcabc");                        // every window holds a repeat
        queue_eol();

        // Random phases across window settings and flow-control mixes
        run_phase(5'd0,  0,  0,  180);
        run_phase(5'd31, 88, 0,  180);
        run_phase(5'd1,  0,  88, 180);
        run_phase(5'd16, 18, 18, 180);
        run_phase(5'd2,  0,  0,  100);
        run_phase(CFG_W'($urandom_range(0, 31)), 18, 18, 180);
        run_phase(CFG_W'($urandom_range(2, 16)), 0,  0,  100);

        repeat (5) @(negedge clk);
        $display("run covered %0d words in %0d lines over %0d window settings",
                 accepted_total, lines_closed, windows_written + 1);
        $display("checked %0d marker results and %0d unmarked line ends",
                 markers_checked, unmarked_checked);
        if (error_count == 0)
            $display("tb_distinct_window_marker_detector_unit: clean");
        else
            $display("tb_distinct_window_marker_detector_unit: errors");
        $finish;
    end

endmodule

>>> filelist.f
src/dwmd_pkg.sv
src/dwmd_cell.sv
src/distinct_window_marker_detector_unit.sv
src/dwmd_checker.sv
test/tb_distinct_window_marker_detector_unit.sv
